[hdl/glr_pkg.sv]
// ----------------------------------------------------------------------------
// glr_pkg
// shared types, codes and glow constants for the glow line rasterizer
// ----------------------------------------------------------------------------
package glr_pkg;

    localparam int MAX_WIDTH_DEF  = 256;
    localparam int MAX_HEIGHT_DEF = 256;
    localparam int CFG_W          = 9;

    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_READ  = 2'd1,
        CMD_LINE  = 2'd2,
        CMD_NOP   = 2'd3
    } cmd_t;

    typedef enum logic {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } reg_index_t;

    typedef struct packed {
        logic [1:0]  command;
        logic [7:0]  start_x;
        logic [7:0]  start_y;
        logic [7:0]  end_x;
        logic [7:0]  end_y;
        logic [31:0] write_value;
    } request_t;

    typedef struct packed {
        logic [31:0] read_value;
        logic [7:0]  steps_walked;
    } result_t;

    localparam logic [31:0] GLOW_BLUE  = 32'h0000_0080;
    localparam logic [31:0] GLOW_CYAN  = 32'h0000_6080;
    localparam logic [31:0] GLOW_WHITE = 32'h0080_8080;
    localparam logic [31:0] KEEP_ONE   = 32'h00ff_feff;
    localparam logic [31:0] KEEP_TWO   = 32'h00fe_feff;
    localparam logic [31:0] CARRY_B    = 32'h0000_0100;
    localparam logic [31:0] CARRY_BG   = 32'h0001_0100;
    localparam logic [31:0] CARRY_BGR  = 32'h0101_0100;

    localparam logic [2:0] TAP_LAST = 3'd4;

    // channel-wise saturating add for one tap of the five-pixel cross
    function automatic logic [31:0] glow_word(input logic [31:0] old_word,
                                              input logic [2:0]  tap);
        logic [31:0] keep;
        logic [31:0] add;
        logic [31:0] carry;
        logic [31:0] sum;
        logic [31:0] ovf;
        unique case (tap)
            3'd0, 3'd4:
            begin
                keep  = KEEP_ONE;
                add   = GLOW_BLUE;
                carry = CARRY_B;
            end
            3'd1, 3'd3:
            begin
                keep  = KEEP_TWO;
                add   = GLOW_CYAN;
                carry = CARRY_BG;
            end
            default:
            begin
                keep  = KEEP_TWO;
                add   = GLOW_WHITE;
                carry = CARRY_BGR;
            end
        endcase
        sum = (old_word & keep) + add;
        ovf = sum & carry;
        // a carry out of a channel fills that channel with ones
        return sum | (ovf - (ovf >> 8));
    endfunction

endpackage

[hdl/glow_line_rasterizer.sv]
// ----------------------------------------------------------------------------
// glow_line_rasterizer
// frame store of 32-bit pixels with a bresenham line engine that lays a
// five-pixel glow cross across the minor axis at each in-band major step
// ----------------------------------------------------------------------------
//  channel   signals                              transfer
//  request   start, busy, request                 start && !busy
//  result    done, result                         done (one cycle, no stall)
//  config    cfg_we, cfg_index, cfg_wdata         cfg_we
//
//  write pixel: decode, mem, done; read pixel: decode, mem, rdwait, done;
//  line: decode, step and adv per major step, five taps per glowing step;
//  every glowed pixel is a read-modify-write (paddr, pread, pwrite) through
//  the single frame store port; reset clears control and sets config to 256
//  by 256; the frame store is not cleared; busy stays high from accept through the done cycle
// ----------------------------------------------------------------------------
module glow_line_rasterizer #(
    parameter int MAX_WIDTH  = glr_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = glr_pkg::MAX_HEIGHT_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  glr_pkg::request_t         request,
    output logic                      done,
    output glr_pkg::result_t          result,
    input  logic                      cfg_we,
    input  logic                      cfg_index,
    input  logic [glr_pkg::CFG_W-1:0] cfg_wdata
);
    import glr_pkg::*;

    localparam int Depth = MAX_WIDTH * MAX_HEIGHT;
    localparam int AddrW = $clog2(Depth);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_MEM,
        S_RDWAIT,
        S_STEP,
        S_PADDR,
        S_PREAD,
        S_PWRITE,
        S_ADV,
        S_DONE
    } state_t;

    state_t             state_reg;
    logic [CFG_W-1:0]   frame_width_reg;
    logic [CFG_W-1:0]   frame_height_reg;
    cmd_t               cmd_reg;
    logic [7:0]         sx_reg, sy_reg, ex_reg, ey_reg;
    logic [31:0]        wval_reg;
    logic [7:0]         x_reg, y_reg;
    logic               horiz_reg;
    logic               dir_neg_reg;
    logic [7:0]         major_reg, minor_reg;
    logic signed [8:0]  err_reg;
    logic [7:0]         cnt_reg;
    logic [2:0]         tap_reg;
    logic [AddrW-1:0]   addr_reg;
    logic [31:0]        read_value_reg;
    logic [7:0]         steps_reg;

    logic [8:0]         w_eff, h_eff;
    logic [8:0]         pix_x, pix_y;
    logic [17:0]        prod;
    logic [18:0]        addr_sum;
    logic [AddrW-1:0]   addr_next;
    logic               ram_we;
    logic [31:0]        ram_wdata, ram_rdata;

    // line setup
    logic signed [8:0]  dx, dy;
    logic [7:0]         adx, ady;
    logic               horiz, swap, dir_neg;

    // step update
    logic [7:0]         m_coord;
    logic [8:0]         m_size;
    logic               in_band;
    logic signed [8:0]  err_sub, err_next;

    always_comb
    begin
        if (frame_width_reg == '0)
            w_eff = 9'd1;
        else if (32'(frame_width_reg) > MAX_WIDTH)
            w_eff = 9'(MAX_WIDTH);
        else
            w_eff = frame_width_reg;
        if (frame_height_reg == '0)
            h_eff = 9'd1;
        else if (32'(frame_height_reg) > MAX_HEIGHT)
            h_eff = 9'(MAX_HEIGHT);
        else
            h_eff = frame_height_reg;
    end

    function automatic logic [7:0] clamp(input logic [7:0] v, input logic [8:0] size);
        if ({1'b0, v} >= size)
            return 8'(size - 9'd1);
        return v;
    endfunction

    // shared address unit: y * stride + x
    always_comb
    begin
        if (state_reg == S_DECODE)
        begin
            pix_x = {1'b0, sx_reg};
            pix_y = {1'b0, sy_reg};
        end
        else if (horiz_reg)
        begin
            pix_x = {1'b0, x_reg};
            pix_y = {1'b0, y_reg} + {6'b0, tap_reg} - 9'd2;
        end
        else
        begin
            pix_x = {1'b0, x_reg} + {6'b0, tap_reg} - 9'd2;
            pix_y = {1'b0, y_reg};
        end
        prod      = 18'(pix_y) * 18'(w_eff);
        addr_sum  = {1'b0, prod} + {10'b0, pix_x};
        addr_next = AddrW'(addr_sum);
    end

    always_comb
    begin
        dx      = $signed({1'b0, ex_reg}) - $signed({1'b0, sx_reg});
        dy      = $signed({1'b0, ey_reg}) - $signed({1'b0, sy_reg});
        adx     = dx[8] ? 8'(-dx) : dx[7:0];
        ady     = dy[8] ? 8'(-dy) : dy[7:0];
        horiz   = adx > ady;
        swap    = horiz ? dx[8] : dy[8];
        dir_neg = horiz ? (dy[8] ^ swap) : (dx[8] ^ swap);
    end

    always_comb
    begin
        m_coord  = horiz_reg ? y_reg : x_reg;
        m_size   = horiz_reg ? h_eff : w_eff;
        in_band  = ({1'b0, m_coord} > 9'd2) && (({1'b0, m_coord} + 9'd2) < m_size);
        err_sub  = err_reg - $signed({1'b0, minor_reg});
        err_next = err_sub[8] ? (err_sub + $signed({1'b0, major_reg})) : err_sub;
    end

    assign ram_we    = (state_reg == S_PWRITE) ||
                       ((state_reg == S_MEM) && (cmd_reg == CMD_WRITE));
    assign ram_wdata = (state_reg == S_PWRITE) ? glow_word(ram_rdata, tap_reg) : wval_reg;

    glr_ram #(
        .WIDTH (32),
        .DEPTH (Depth)
    ) u_frame_store (
        .clk   (clk),
        .we    (ram_we),
        .addr  (addr_reg),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            frame_width_reg  <= 9'd256;
            frame_height_reg <= 9'd256;
            cmd_reg          <= CMD_NOP;
            sx_reg           <= '0;
            sy_reg           <= '0;
            ex_reg           <= '0;
            ey_reg           <= '0;
            wval_reg         <= '0;
            x_reg            <= '0;
            y_reg            <= '0;
            horiz_reg        <= 1'b0;
            dir_neg_reg      <= 1'b0;
            major_reg        <= '0;
            minor_reg        <= '0;
            err_reg          <= '0;
            cnt_reg          <= '0;
            tap_reg          <= '0;
            addr_reg         <= '0;
            read_value_reg   <= '0;
            steps_reg        <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (reg_index_t'(cfg_index))
                    REG_FRAME_WIDTH:  frame_width_reg  <= cfg_wdata;
                    REG_FRAME_HEIGHT: frame_height_reg <= cfg_wdata;
                endcase
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        cmd_reg   <= cmd_t'(request.command);
                        sx_reg    <= clamp(request.start_x, w_eff);
                        sy_reg    <= clamp(request.start_y, h_eff);
                        ex_reg    <= clamp(request.end_x, w_eff);
                        ey_reg    <= clamp(request.end_y, h_eff);
                        wval_reg  <= request.write_value;
                        state_reg <= S_DECODE;
                    end
                end
                S_DECODE:
                begin
                    read_value_reg <= '0;
                    steps_reg      <= '0;
                    addr_reg       <= addr_next;
                    unique case (cmd_reg)
                        CMD_WRITE, CMD_READ:
                            state_reg <= S_MEM;
                        CMD_LINE:
                        begin
                            // walk upward along the major axis
                            x_reg       <= swap ? ex_reg : sx_reg;
                            y_reg       <= swap ? ey_reg : sy_reg;
                            horiz_reg   <= horiz;
                            dir_neg_reg <= dir_neg;
                            major_reg   <= horiz ? adx : ady;
                            minor_reg   <= horiz ? ady : adx;
                            err_reg     <= $signed({1'b0, (horiz ? adx : ady)});
                            cnt_reg     <= '0;
                            state_reg   <= S_STEP;
                        end
                        CMD_NOP:
                            state_reg <= S_DONE;
                    endcase
                end
                S_MEM:
                begin
                    state_reg <= (cmd_reg == CMD_READ) ? S_RDWAIT : S_DONE;
                end
                S_RDWAIT:
                begin
                    read_value_reg <= ram_rdata;
                    state_reg      <= S_DONE;
                end
                S_STEP:
                begin
                    tap_reg <= '0;
                    priority if (cnt_reg == major_reg)
                    begin
                        steps_reg <= major_reg;
                        state_reg <= S_DONE;
                    end
                    else if (in_band)
                        state_reg <= S_PADDR;
                    else
                        state_reg <= S_ADV;
                end
                S_PADDR:
                begin
                    addr_reg  <= addr_next;
                    state_reg <= S_PREAD;
                end
                S_PREAD:
                begin
                    state_reg <= S_PWRITE;
                end
                S_PWRITE:
                begin
                    if (tap_reg == TAP_LAST)
                        state_reg <= S_ADV;
                    else
                    begin
                        tap_reg   <= tap_reg + 3'd1;
                        state_reg <= S_PADDR;
                    end
                end
                S_ADV:
                begin
                    cnt_reg <= cnt_reg + 8'd1;
                    err_reg <= err_next;
                    if (horiz_reg)
                    begin
                        x_reg <= x_reg + 8'd1;
                        if (err_sub[8])
                            y_reg <= dir_neg_reg ? (y_reg - 8'd1) : (y_reg + 8'd1);
                    end
                    else
                    begin
                        y_reg <= y_reg + 8'd1;
                        if (err_sub[8])
                            x_reg <= dir_neg_reg ? (x_reg - 8'd1) : (x_reg + 8'd1);
                    end
                    state_reg <= S_STEP;
                end
                S_DONE:
                begin
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign busy                = (state_reg != S_IDLE);
    assign done                = (state_reg == S_DONE);
    assign result.read_value   = read_value_reg;
    assign result.steps_walked = steps_reg;

endmodule

[hdl/glr_ram.sv]
// ----------------------------------------------------------------------------
// glr_ram
// single-port ram, one write or read per cycle, registered read data
// ----------------------------------------------------------------------------
module glr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AddrW-1:0] addr,
    input  logic [WIDTH-1:0] wdata,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

[hdl/glr_checker.sv]
// ----------------------------------------------------------------------------
// glr_port_checks
// port-level checks on the command and result timing of the rasterizer
// ----------------------------------------------------------------------------
module glr_port_checks (
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input logic              done,
    input glr_pkg::result_t  result
);
    import glr_pkg::*;

    // an accepted word keeps the block busy
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("block not busy after accepting a word");

    // a result only shows while the command is still in flight
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("result strobe without a command in flight");

    // exactly one result per command, then the block frees up
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done && !busy)
        else $error("result strobe not followed by idle");

    // a line result carries no pixel word
    a_line_no_pixel: assert property (@(posedge clk) disable iff (!rst_n)
        done && (result.steps_walked != 8'd0) |-> (result.read_value == 32'd0))
        else $error("line result with nonzero pixel word");

endmodule

bind glow_line_rasterizer glr_port_checks u_glr_port_checks (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);

[tb/sv/glr_checker.sv]
// ----------------------------------------------------------------------------
// glr_checker
// watches the command, result and config channels of the glow line
// rasterizer, keeps its own copy of the frame store, predicts every result
// word and compares it field by field against what the block returns
// ----------------------------------------------------------------------------
module glr_checker #(
    parameter int MAX_WIDTH  = glr_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = glr_pkg::MAX_HEIGHT_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic                      busy,
    input  glr_pkg::request_t         request,
    input  logic                      done,
    input  glr_pkg::result_t          result,
    input  logic                      cfg_we,
    input  logic                      cfg_index,
    input  logic [glr_pkg::CFG_W-1:0] cfg_wdata,
    output int                        failures
);
    timeunit 1ns;
    timeprecision 1ps;

    import glr_pkg::*;

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;

    logic [31:0]      pixels [DEPTH];
    logic [CFG_W-1:0] width_raw;
    logic [CFG_W-1:0] height_raw;
    result_t          pending_results[$];
    int               mismatches = 0;

    function automatic int active_size(input logic [CFG_W-1:0] v, input int maxv);
        if (v == 0)
        begin
            return 1;
        end
        if (int'(v) > maxv)
        begin
            return maxv;
        end
        return int'(v);
    endfunction

    function automatic int pin(input int v, input int size);
        return (v >= size) ? size - 1 : v;
    endfunction

    // ring 0 is the center (white), 1 the inner pair (cyan), 2 the outer pair (blue)
    function automatic logic [31:0] brighten(input logic [31:0] old, input int ring);
        logic [31:0] keep;
        logic [31:0] add;
        logic [31:0] carry;
        logic [31:0] sum;
        logic [31:0] ovf;
        case (ring)
            0:
            begin
                keep  = KEEP_TWO;
                add   = GLOW_WHITE;
                carry = CARRY_BGR;
            end
            1:
            begin
                keep  = KEEP_TWO;
                add   = GLOW_CYAN;
                carry = CARRY_BG;
            end
            default:
            begin
                keep  = KEEP_ONE;
                add   = GLOW_BLUE;
                carry = CARRY_B;
            end
        endcase
        sum = (old & keep) + add;
        ovf = sum & carry;
        // overflowed channel saturates, its carry bit stays in the next channel
        return sum | (ovf - (ovf >> 8));
    endfunction

    function automatic logic [7:0] walk_line(input int x1, input int y1, input int x2,
                                             input int y2, input int w, input int h);
        int dx;
        int dy;
        int adx;
        int ady;
        int x;
        int y;
        int major;
        int minor;
        int err;
        int dir;
        int lim;
        int m;
        int i;
        int k;
        int idx;
        bit horiz;
        dx    = x2 - x1;
        dy    = y2 - y1;
        adx   = (dx < 0) ? -dx : dx;
        ady   = (dy < 0) ? -dy : dy;
        horiz = adx > ady;
        // walk the major axis upward
        if ((horiz && dx < 0) || (!horiz && dy < 0))
        begin
            x  = x2;
            y  = y2;
            dx = -dx;
            dy = -dy;
        end
        else
        begin
            x = x1;
            y = y1;
        end
        major = horiz ? adx : ady;
        minor = horiz ? ady : adx;
        dir   = horiz ? ((dy < 0) ? -1 : 1) : ((dx < 0) ? -1 : 1);
        lim   = horiz ? h : w;
        err   = major;
        for (i = 0; i < major; i++)
        begin
            m = horiz ? y : x;
            if (m > 2 && m < lim - 2)
            begin
                for (k = -2; k <= 2; k++)
                begin
                    idx = horiz ? (y + k) * w + x : y * w + x + k;
                    pixels[idx] = brighten(pixels[idx], (k < 0) ? -k : k);
                end
            end
            if (horiz)
            begin
                x++;
            end
            else
            begin
                y++;
            end
            err -= minor;
            if (err < 0)
            begin
                err += major;
                if (horiz)
                begin
                    y += dir;
                end
                else
                begin
                    x += dir;
                end
            end
        end
        return major[7:0];
    endfunction

    function automatic result_t compute_result(input request_t word);
        int      w;
        int      h;
        int      sx;
        int      sy;
        int      ex;
        int      ey;
        int      idx;
        result_t res;
        w   = active_size(width_raw, MAX_WIDTH);
        h   = active_size(height_raw, MAX_HEIGHT);
        sx  = pin(int'(word.start_x), w);
        sy  = pin(int'(word.start_y), h);
        ex  = pin(int'(word.end_x), w);
        ey  = pin(int'(word.end_y), h);
        idx = sy * w + sx;
        res = '0;
        case (cmd_t'(word.command))
            CMD_WRITE: pixels[idx] = word.write_value;
            CMD_READ:  res.read_value = pixels[idx];
            CMD_LINE:  res.steps_walked = walk_line(sx, sy, ex, ey, w, h);
            default:   ;
        endcase
        return res;
    endfunction

    task automatic report(input string what, input logic [31:0] got,
                          input logic [31:0] want);
        // keep the log short on a badly broken block
        if (mismatches < 50)
        begin
            $display("%0t: %s mismatch: got %h expected %h", $realtime, what, got, want);
        end
        mismatches++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            width_raw  = CFG_W'(MAX_WIDTH_DEF);
            height_raw = CFG_W'(MAX_HEIGHT_DEF);
            pending_results.delete();
            failures   = mismatches;
        end
        else
        begin
            if (cfg_we)
            begin
                case (reg_index_t'(cfg_index))
                    REG_FRAME_WIDTH:  width_raw = cfg_wdata;
                    REG_FRAME_HEIGHT: height_raw = cfg_wdata;
                endcase
            end
            if (done)
            begin
                if (pending_results.size() == 0)
                begin
                    report("unexpected word", result.read_value, '0);
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (result.read_value !== want.read_value)
                    begin
                        report("read_value", result.read_value, want.read_value);
                    end
                    if (result.steps_walked !== want.steps_walked)
                    begin
                        report("steps_walked", 32'(result.steps_walked),
                               32'(want.steps_walked));
                    end
                end
            end
            if (start && !busy)
            begin
                pending_results.push_back(compute_result(request));
            end
            failures = mismatches + pending_results.size();
        end
    end

endmodule

[tb/sv/tb_glow_line_rasterizer.sv]
// ----------------------------------------------------------------------------
// tb_glow_line_rasterizer
// drives pixel writes, reads, nops and glow lines into the rasterizer across a
// series of frame sizes; every pixel a command touches is written first, the
// checker beside the block predicts and compares each result word
// ----------------------------------------------------------------------------
module tb_glow_line_rasterizer;
    timeunit 1ns;
    timeprecision 1ps;

    import glr_pkg::*;

    localparam int     MAX_W           = MAX_WIDTH_DEF;
    localparam int     MAX_H           = MAX_HEIGHT_DEF;
    localparam int     ITEMS_PER_PHASE = 24;
    localparam int     PHASES          = 10;
    localparam longint CYCLE_LIMIT     = 10_000_000;

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             start     = 1'b0;
    logic             busy;
    request_t         request   = '0;
    logic             done;
    result_t          result;
    logic             cfg_we    = 1'b0;
    logic             cfg_index = 1'b0;
    logic [CFG_W-1:0] cfg_wdata = '0;
    int               failures;

    int     issued       = 0;
    int     results_seen = 0;
    int     burst_left   = 0;
    longint cycles       = 0;
    int     eff_w        = MAX_W;
    int     eff_h        = MAX_H;
    bit     written [MAX_W*MAX_H];

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    glow_line_rasterizer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .request   (request),
        .done      (done),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    glr_checker u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .request   (request),
        .done      (done),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .failures  (failures)
    );

    always @(posedge clk)
    begin
        cycles++;
        if (done)
        begin
            results_seen <= results_seen + 1;
        end
        if (cycles > CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    function automatic int active_size(input int v, input int maxv);
        if (v == 0)
        begin
            return 1;
        end
        return (v > maxv) ? maxv : v;
    endfunction

    function automatic int pin(input int v, input int size);
        return (v >= size) ? size - 1 : v;
    endfunction

    // random word, often with channels parked near saturation
    function automatic logic [31:0] rand_word();
        logic [31:0] v;
        int          b;
        v = $urandom;
        if ($urandom_range(0, 1) == 1)
        begin
            for (b = 0; b < 4; b++)
            begin
                case ($urandom_range(0, 3))
                    0:       v[8*b +: 8] = 8'hff;
                    1:       v[8*b +: 8] = 8'h7f;
                    2:       v[8*b +: 8] = 8'h80;
                    default: ;
                endcase
            end
        end
        return v;
    endfunction

    function automatic int pick_coord(input int size);
        case ($urandom_range(0, 9))
            0:       return $urandom_range(0, 255);
            1:       return size - 1;
            2:       return $urandom_range(2, 3);
            3:       return (size > 3) ? size - 3 : 0;
            default: return $urandom_range(0, size - 1);
        endcase
    endfunction

    // second endpoint: short hops outside the tiniest frames keep the priming cheap
    function automatic int toward(input int c, input int size);
        int v;
        if (size > 8)
        begin
            v = c + $urandom_range(0, 8) - 4;
            return (v < 0) ? 0 : ((v > 255) ? 255 : v);
        end
        return pick_coord(size);
    endfunction

    task automatic issue(input request_t word);
        int gap;
        if (burst_left > 0)
        begin
            gap = 0;
            burst_left--;
        end
        else
        begin
            gap = $urandom_range(0, 4);
            if ($urandom_range(0, 15) == 0)
            begin
                burst_left = $urandom_range(4, 16);
            end
        end
        if (gap > 0)
        begin
            start <= 1'b0;
            // sometimes count the gap from the end of the current word
            if ($urandom_range(0, 1) == 1)
            begin
                while (busy)
                begin
                    @(posedge clk);
                end
            end
            repeat (gap) @(posedge clk);
        end
        start   <= 1'b1;
        request <= word;
        do
        begin
            @(posedge clk);
        end
        while (busy);
        issued++;
    endtask

    task automatic write_pixel(input int x, input int y, input logic [31:0] v);
        written[pin(y, eff_h) * eff_w + pin(x, eff_w)] = 1'b1;
        issue('{command: CMD_WRITE, start_x: 8'(x), start_y: 8'(y),
                end_x: 8'($urandom), end_y: 8'($urandom), write_value: v});
    endtask

    // frame store words are undefined until written
    task automatic make_ready(input int x, input int y);
        if (!written[y * eff_w + x])
        begin
            write_pixel(x, y, rand_word());
        end
    endtask

    task automatic read_pixel(input int x, input int y);
        make_ready(pin(x, eff_w), pin(y, eff_h));
        issue('{command: CMD_READ, start_x: 8'(x), start_y: 8'(y),
                end_x: 8'($urandom), end_y: 8'($urandom), write_value: $urandom});
    endtask

    // write every pixel the glow cross will touch before the line goes out
    task automatic prime_line(input int x1, input int y1, input int x2, input int y2);
        int dx;
        int dy;
        int adx;
        int ady;
        int x;
        int y;
        int major;
        int minor;
        int err;
        int dir;
        int lim;
        int m;
        int i;
        int k;
        bit horiz;
        dx    = x2 - x1;
        dy    = y2 - y1;
        adx   = (dx < 0) ? -dx : dx;
        ady   = (dy < 0) ? -dy : dy;
        horiz = adx > ady;
        if ((horiz && dx < 0) || (!horiz && dy < 0))
        begin
            x  = x2;
            y  = y2;
            dx = -dx;
            dy = -dy;
        end
        else
        begin
            x = x1;
            y = y1;
        end
        major = horiz ? adx : ady;
        minor = horiz ? ady : adx;
        dir   = horiz ? ((dy < 0) ? -1 : 1) : ((dx < 0) ? -1 : 1);
        lim   = horiz ? eff_h : eff_w;
        err   = major;
        for (i = 0; i < major; i++)
        begin
            m = horiz ? y : x;
            if (m > 2 && m < lim - 2)
            begin
                for (k = -2; k <= 2; k++)
                begin
                    if (horiz)
                    begin
                        make_ready(x, y + k);
                    end
                    else
                    begin
                        make_ready(x + k, y);
                    end
                end
            end
            if (horiz)
            begin
                x++;
            end
            else
            begin
                y++;
            end
            err -= minor;
            if (err < 0)
            begin
                err += major;
                if (horiz)
                begin
                    y += dir;
                end
                else
                begin
                    x += dir;
                end
            end
        end
    endtask

    task automatic draw(input int x1, input int y1, input int x2, input int y2);
        prime_line(pin(x1, eff_w), pin(y1, eff_h), pin(x2, eff_w), pin(y2, eff_h));
        issue('{command: CMD_LINE, start_x: 8'(x1), start_y: 8'(y1),
                end_x: 8'(x2), end_y: 8'(y2), write_value: $urandom});
    endtask

    task automatic drain();
        start <= 1'b0;
        while (results_seen < issued)
        begin
            @(posedge clk);
        end
    endtask

    task automatic set_frame(input int w, input int h);
        drain();
        cfg_we    <= 1'b1;
        cfg_index <= REG_FRAME_WIDTH;
        cfg_wdata <= CFG_W'(w);
        @(posedge clk);
        cfg_index <= REG_FRAME_HEIGHT;
        cfg_wdata <= CFG_W'(h);
        @(posedge clk);
        cfg_we <= 1'b0;
        eff_w = active_size(w, MAX_W);
        eff_h = active_size(h, MAX_H);
    endtask

    task automatic random_item();
        int pick;
        int x1;
        int y1;
        pick = $urandom_range(0, 19);
        x1   = pick_coord(eff_w);
        y1   = pick_coord(eff_h);
        if (pick < 5)
        begin
            write_pixel(x1, y1, rand_word());
        end
        else if (pick < 11)
        begin
            read_pixel(x1, y1);
        end
        else if (pick < 19)
        begin
            draw(x1, y1, toward(x1, eff_w), toward(y1, eff_h));
        end
        else
        begin
            issue('{command: CMD_NOP, start_x: 8'($urandom), start_y: 8'($urandom),
                    end_x: 8'($urandom), end_y: 8'($urandom), write_value: $urandom});
        end
    endtask

    initial
    begin
        int phase;
        int phase_base;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // directed words at the reset frame size
        write_pixel(0, 0, 32'h0000_0000);
        write_pixel(255, 255, 32'hffff_ffff);
        read_pixel(0, 0);
        read_pixel(255, 255);
        issue('{command: CMD_NOP, start_x: 8'hff, start_y: 8'hff,
                end_x: 8'hff, end_y: 8'hff, write_value: 32'hffff_ffff});
        draw(10, 10, 10, 10);
        draw(10, 20, 14, 20);
        draw(14, 40, 10, 41);
        draw(30, 10, 30, 14);
        draw(31, 14, 32, 10);
        draw(50, 50, 54, 54);
        draw(60, 54, 56, 50);
        // minor coordinate at the glow limits on both sides
        draw(100, 2, 104, 2);
        draw(100, 3, 104, 3);
        draw(100, 253, 103, 253);
        draw(100, 254, 103, 254);
        // saturating channels under the cross
        write_pixel(20, 60, 32'hffff_ffff);
        write_pixel(20, 61, 32'h01ff_7f80);
        draw(18, 60, 22, 60);
        read_pixel(20, 60);
        read_pixel(20, 61);
        read_pixel(12, 20);
        draw(70, 70, 72, 76);
        // full-length lines that stay outside the glow band
        draw(0, 1, 255, 2);
        draw(2, 0, 1, 255);

        for (phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0:       set_frame(0, 0);
                1:       set_frame(511, 300);
                2:       set_frame(1, 256);
                3:       set_frame(256, 1);
                4:       set_frame(5, 5);
                5:       set_frame(256, 256);
                default: set_frame($urandom_range(6, 48), $urandom_range(6, 48));
            endcase
            // priming writes count toward the phase budget
            phase_base = issued;
            while (issued - phase_base < ITEMS_PER_PHASE)
            begin
                random_item();
            end
        end

        drain();
        repeat (8) @(posedge clk);
        if (failures == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

[files.f]
hdl/glr_pkg.sv
hdl/glr_ram.sv
hdl/glow_line_rasterizer.sv
hdl/glr_checker.sv
tb/sv/glr_checker.sv
tb/sv/tb_glow_line_rasterizer.sv
